[rtl/pats_pkg.sv]
package pats_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_SILENCE = 2'd2
  } op_e;

  localparam logic [2:0] ALARM_ALL     = 3'd0;
  localparam logic [2:0] ALARM_MAX     = 3'd3;
  localparam logic [1:0] ALARM_NONE    = 2'd0;
  localparam logic [1:0] ALARM_DEPTH   = 2'd1;
  localparam logic [1:0] ALARM_ASCENT  = 2'd2;
  localparam logic [1:0] ALARM_OUT_AIR = 2'd3;
  localparam int unsigned MaxTicks     = 63;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] alarm_id;
  } item_t;

  typedef struct packed {
    logic       tone_on;
    logic [7:0] tone_divider;
    logic [1:0] playing_alarm;
    logic [2:0] note_position;
    logic [2:0] active_mask;
    logic       bad_request;
  } result_t;

  // one-hot position of an alarm in the active set
  function automatic logic [2:0] alarm_bit(logic [1:0] alarm);
    logic [2:0] m;
    case (alarm)
      ALARM_DEPTH:   m = 3'b001;
      ALARM_ASCENT:  m = 3'b010;
      ALARM_OUT_AIR: m = 3'b100;
      default:       m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] highest_alarm(logic [2:0] set);
    logic [1:0] a;
    if (set[2]) begin
      a = ALARM_OUT_AIR;
    end else if (set[1]) begin
      a = ALARM_ASCENT;
    end else if (set[0]) begin
      a = ALARM_DEPTH;
    end else begin
      a = ALARM_NONE;
    end
    return a;
  endfunction

  // index of the final note of each pattern
  function automatic logic [2:0] last_note(logic [1:0] alarm);
    logic [2:0] n;
    case (alarm)
      ALARM_DEPTH:   n = 3'd1;
      ALARM_ASCENT:  n = 3'd1;
      ALARM_OUT_AIR: n = 3'd7;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] note_pitch(logic [1:0] alarm, logic [2:0] note);
    logic [7:0] p;
    p = 8'h00;
    case (alarm)
      ALARM_DEPTH: begin
        case (note)
          3'd0:    p = 8'h20;
          3'd1:    p = 8'h80;
          default: p = 8'h00;
        endcase
      end
      ALARM_ASCENT: begin
        case (note)
          3'd0:    p = 8'h80;
          3'd1:    p = 8'hD0;
          default: p = 8'h00;
        endcase
      end
      ALARM_OUT_AIR: begin
        case (note)
          3'd0, 3'd2: p = 8'h20;
          3'd4, 3'd6: p = 8'hD0;
          default:    p = 8'h00;
        endcase
      end
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

[rtl/pats_in_if.sv]
interface pats_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] alarm_id;

  modport source (output valid, output opcode, output alarm_id, input ready);
  modport sink (input valid, input opcode, input alarm_id, output ready);
endinterface

[rtl/pats_out_if.sv]
interface pats_out_if;
  logic       valid;
  logic       ready;
  logic       tone_on;
  logic [7:0] tone_divider;
  logic [1:0] playing_alarm;
  logic [2:0] note_position;
  logic [2:0] active_mask;
  logic       bad_request;

  modport source (
    output valid, output tone_on, output tone_divider, output playing_alarm,
    output note_position, output active_mask, output bad_request, input ready
  );
  modport sink (
    input valid, input tone_on, input tone_divider, input playing_alarm,
    input note_position, input active_mask, input bad_request, output ready
  );
endinterface

[rtl/pats_core.sv]
module pats_core #(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pats_pkg::item_t     item_i,
  output pats_pkg::result_t   result_o
);

  localparam int unsigned HalfRaw    = TICKS_PER_SECOND / 2;
  localparam int unsigned QuarterRaw = TICKS_PER_SECOND / 4;
  localparam logic [5:0] HalfTicks =
    (HalfRaw > pats_pkg::MaxTicks) ? 6'(pats_pkg::MaxTicks) :
    (HalfRaw < 1) ? 6'd1 : 6'(HalfRaw);
  localparam logic [5:0] QuarterTicks =
    (QuarterRaw > pats_pkg::MaxTicks) ? 6'(pats_pkg::MaxTicks) :
    (QuarterRaw < 1) ? 6'd1 : 6'(QuarterRaw);

  logic [2:0] active_q, active_d;
  logic [1:0] alarm_q, alarm_d;
  logic [2:0] note_q, note_d;
  logic [5:0] ticks_q, ticks_d;
  logic       playing_q, playing_d;
  logic       bad;
  logic [2:0] sel_bit;
  logic [1:0] top_alarm;

  function automatic logic [5:0] note_ticks(logic [1:0] alarm);
    return (alarm == pats_pkg::ALARM_OUT_AIR) ? QuarterTicks : HalfTicks;
  endfunction

  assign sel_bit = pats_pkg::alarm_bit(item_i.alarm_id[1:0]);

  always_comb begin
    active_d  = active_q;
    alarm_d   = alarm_q;
    note_d    = note_q;
    ticks_d   = ticks_q;
    playing_d = playing_q;
    bad       = 1'b0;
    top_alarm = pats_pkg::ALARM_NONE;
    case (pats_pkg::op_e'(item_i.opcode))
      pats_pkg::OP_TICK: begin
        if (playing_q) begin
          if (ticks_q <= 6'd1) begin
            note_d  = (note_q == pats_pkg::last_note(alarm_q)) ? 3'd0 : note_q + 3'd1;
            ticks_d = note_ticks(alarm_q);
          end else begin
            ticks_d = ticks_q - 6'd1;
          end
        end
      end
      pats_pkg::OP_REQUEST: begin
        if (item_i.alarm_id == pats_pkg::ALARM_ALL ||
            item_i.alarm_id > pats_pkg::ALARM_MAX) begin
          bad = 1'b1;
        end else if ((active_q & sel_bit) == 3'b000) begin
          active_d  = active_q | sel_bit;
          top_alarm = pats_pkg::highest_alarm(active_d);
          alarm_d   = top_alarm;
          note_d    = 3'd0;
          playing_d = 1'b1;
          ticks_d   = note_ticks(top_alarm);
        end
      end
      pats_pkg::OP_SILENCE: begin
        if (item_i.alarm_id > pats_pkg::ALARM_MAX) begin
          bad = 1'b1;
        end else begin
          active_d  = (item_i.alarm_id == pats_pkg::ALARM_ALL) ? 3'b000
                                                               : (active_q & ~sel_bit);
          top_alarm = pats_pkg::highest_alarm(active_d);
          if (active_d == 3'b000) begin
            alarm_d   = pats_pkg::ALARM_NONE;
            note_d    = 3'd0;
            ticks_d   = 6'd0;
            playing_d = 1'b0;
          end else if (top_alarm != alarm_q) begin
            alarm_d   = top_alarm;
            note_d    = 3'd0;
            playing_d = 1'b1;
            ticks_d   = note_ticks(top_alarm);
          end
        end
      end
      default: begin
        bad = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_o.tone_on       = playing_d;
    result_o.tone_divider  = playing_d ? pats_pkg::note_pitch(alarm_d, note_d) : 8'h00;
    result_o.playing_alarm = playing_d ? alarm_d : pats_pkg::ALARM_NONE;
    result_o.note_position = playing_d ? note_d : 3'd0;
    result_o.active_mask   = active_d;
    result_o.bad_request   = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 3'b000;
      alarm_q   <= pats_pkg::ALARM_NONE;
      note_q    <= 3'd0;
      ticks_q   <= 6'd0;
      playing_q <= 1'b0;
    end else if (step_i) begin
      active_q  <= active_d;
      alarm_q   <= alarm_d;
      note_q    <= note_d;
      ticks_q   <= ticks_d;
      playing_q <= playing_d;
    end
  end

endmodule

[rtl/priority_alarm_tone_sequencer.sv]
// a word passes the input register, then the output one; throughput: one word per
// cycle unless the output stalls; the alarm state is updated in the same cycle the
// word leaves the input register, so each word sees the state left by the one before
// reset (rst_ni low, asynchronous): both registers empty, no alarm active, tone off
module priority_alarm_tone_sequencer #(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input logic         clk_i,
  input logic         rst_ni,
  pats_in_if.sink     in_i,
  pats_out_if.source  out_o
);

  logic              in_valid_q;
  pats_pkg::item_t   item_q;
  logic              out_valid_q;
  pats_pkg::result_t res_q;
  pats_pkg::result_t result;
  logic              advance;
  logic              step;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode   <= in_i.opcode;
      item_q.alarm_id <= in_i.alarm_id;
    end
  end

  pats_core #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.tone_on       = res_q.tone_on;
  assign out_o.tone_divider  = res_q.tone_divider;
  assign out_o.playing_alarm = res_q.playing_alarm;
  assign out_o.note_position = res_q.note_position;
  assign out_o.active_mask   = res_q.active_mask;
  assign out_o.bad_request   = res_q.bad_request;

  // silent word carries no note information
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.tone_on |->
      res_q.tone_divider == 8'h00 && res_q.playing_alarm == pats_pkg::ALARM_NONE &&
      res_q.note_position == 3'd0)
    else $error("silent result with note fields set");

  // the alarm played is always the highest one in the active set
  a_plays_highest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      res_q.playing_alarm == pats_pkg::highest_alarm(res_q.active_mask) &&
      res_q.tone_on == (res_q.active_mask != 3'b000))
    else $error("played alarm does not match active set");

  // a stalled input word is held until it is processed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("stalled input word lost or changed");

  // every processed word produces a result
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed word produced no result");

endmodule

[tb/priority_alarm_tone_sequencer_tb.sv]
`timescale 1ns / 1ps

module priority_alarm_tone_sequencer_tb;

  localparam int unsigned TPS         = 100;
  localparam int unsigned N_ITEMS     = 500;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] A_DEPTH      = {1'b0, pats_pkg::ALARM_DEPTH};
  localparam logic [2:0] A_ASCENT     = {1'b0, pats_pkg::ALARM_ASCENT};
  localparam logic [2:0] A_OUT_AIR    = {1'b0, pats_pkg::ALARM_OUT_AIR};
  localparam logic [2:0] ALARM_BAD_LO = 3'd4;
  localparam logic [2:0] ALARM_BAD_HI = 3'd7;

  class tone_tracker;
    string             tag;
    logic [5:0]        half_len;
    logic [5:0]        quarter_len;
    logic [2:0]        active;
    logic [1:0]        alarm;
    logic [2:0]        note;
    logic [5:0]        left;
    logic              playing;
    logic [7:0]        pitch_tab [4][8];
    int unsigned       notes_in [4];
    pats_pkg::result_t tones_due[$];
    int unsigned       mismatches;

    function new(string name, int unsigned tps);
      tag         = name;
      half_len    = clip_len(tps / 2);
      quarter_len = clip_len(tps / 4);
      pitch_tab   = '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                      '{8'h20, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                      '{8'h80, 8'hD0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                      '{8'h20, 8'h00, 8'h20, 8'h00, 8'hD0, 8'h00, 8'hD0, 8'h00}};
      notes_in    = '{1, 2, 2, 8};
      active      = '0;
      mismatches  = 0;
      silence();
    endfunction

    function logic [5:0] clip_len(int unsigned d);
      if (d > 63) return 6'd63;
      if (d < 1) return 6'd1;
      return d[5:0];
    endfunction

    function void silence();
      playing = 1'b0;
      alarm   = pats_pkg::ALARM_NONE;
      note    = '0;
      left    = '0;
    endfunction

    function void start_note();
      playing = 1'b1;
      left    = (alarm == pats_pkg::ALARM_OUT_AIR) ? quarter_len : half_len;
    endfunction

    function logic [1:0] top_alarm();
      if (active[2]) return pats_pkg::ALARM_OUT_AIR;
      if (active[1]) return pats_pkg::ALARM_ASCENT;
      if (active[0]) return pats_pkg::ALARM_DEPTH;
      return pats_pkg::ALARM_NONE;
    endfunction

    function int unsigned waiting();
      return tones_due.size();
    endfunction

    function void take_command(pats_pkg::item_t w);
      pats_pkg::result_t r;
      logic              bad;
      logic [2:0]        bit_m;
      logic [1:0]        hi;
      bad   = 1'b0;
      bit_m = 3'b001 << (w.alarm_id - 3'd1);
      case (w.opcode)
        pats_pkg::OP_TICK: begin
          if (playing) begin
            if (left <= 1) begin
              if (int'(note) + 1 >= notes_in[alarm]) note = '0;
              else note = note + 3'd1;
              start_note();
            end else begin
              left = left - 6'd1;
            end
          end
        end
        pats_pkg::OP_REQUEST: begin
          if (w.alarm_id == pats_pkg::ALARM_ALL || w.alarm_id > pats_pkg::ALARM_MAX) begin
            bad = 1'b1;
          end else if ((active & bit_m) == '0) begin
            active = active | bit_m;
            alarm  = top_alarm();
            note   = '0;
            start_note();
          end
        end
        pats_pkg::OP_SILENCE: begin
          if (w.alarm_id > pats_pkg::ALARM_MAX) begin
            bad = 1'b1;
          end else if (w.alarm_id == pats_pkg::ALARM_ALL) begin
            active = '0;
            silence();
          end else begin
            active = active & ~bit_m;
            if (active == '0) begin
              silence();
            end else begin
              hi = top_alarm();
              // a silenced background alarm leaves the playing note alone
              if (hi != alarm) begin
                alarm = hi;
                note  = '0;
                start_note();
              end
            end
          end
        end
        default: ;
      endcase
      r.tone_on       = playing;
      r.tone_divider  = playing ? pitch_tab[alarm][note] : 8'h00;
      r.playing_alarm = playing ? alarm : pats_pkg::ALARM_NONE;
      r.note_position = playing ? note : 3'd0;
      r.active_mask   = active;
      r.bad_request   = bad;
      tones_due.push_back(r);
    endfunction

    task report(string line);
      mismatches++;
      $display("%s: %s", tag, line);
    endtask

    task check_tone(pats_pkg::result_t got);
      pats_pkg::result_t want;
      if (tones_due.size() == 0) begin
        report($sformatf("word %h with nothing expected", got));
        return;
      end
      want = tones_due.pop_front();
      if (got.tone_on !== want.tone_on)
        report($sformatf("tone_on %0b, expected %0b", got.tone_on, want.tone_on));
      if (got.tone_divider !== want.tone_divider)
        report($sformatf("tone_divider %0h, expected %0h", got.tone_divider,
                         want.tone_divider));
      if (got.playing_alarm !== want.playing_alarm)
        report($sformatf("playing_alarm %0d, expected %0d", got.playing_alarm,
                         want.playing_alarm));
      if (got.note_position !== want.note_position)
        report($sformatf("note_position %0d, expected %0d", got.note_position,
                         want.note_position));
      if (got.active_mask !== want.active_mask)
        report($sformatf("active_mask %b, expected %b", got.active_mask, want.active_mask));
      if (got.bad_request !== want.bad_request)
        report($sformatf("bad_request %0b, expected %0b", got.bad_request,
                         want.bad_request));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned cycles = 0;

  pats_in_if  in_bus ();
  pats_out_if out_bus ();

  priority_alarm_tone_sequencer #(
    .TICKS_PER_SECOND(TPS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  tone_tracker tracker;
  logic        steady = 1'b0;
  int unsigned sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned pick_gap();
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [2:0] typ);
    pats_pkg::item_t w;
    int unsigned     gap;
    w.opcode   = op;
    w.alarm_id = typ;
    gap        = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= w.opcode;
    in_bus.alarm_id <= w.alarm_id;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker.take_command(w);
    sent++;
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) send_word(pats_pkg::OP_TICK, 3'($urandom_range(0, 7)));
  endtask

  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.waiting() != 0);
  endtask

  // requests, a run of ticks with the odd interruption, then silences
  task automatic play_sequence();
    int unsigned run;
    repeat ($urandom_range(1, 3))
      send_word(pats_pkg::OP_REQUEST, 3'($urandom_range(1, 3)));
    if ($urandom_range(0, 3) == 0) run = $urandom_range(0, 9 * tracker.quarter_len);
    else run = $urandom_range(0, tracker.half_len + 2);
    if (sent + run > N_ITEMS) run = (sent < N_ITEMS) ? N_ITEMS - sent : 0;
    repeat (run) begin
      if ($urandom_range(0, 19) == 0)
        send_word(pats_pkg::OP_REQUEST, 3'($urandom_range(1, 3)));
      else if ($urandom_range(0, 29) == 0)
        send_word(pats_pkg::OP_SILENCE, 3'($urandom_range(1, 3)));
      else send_word(pats_pkg::OP_TICK, 3'($urandom_range(0, 7)));
    end
    repeat ($urandom_range(1, 3))
      send_word(pats_pkg::OP_SILENCE, 3'($urandom_range(0, 3)));
  endtask

  initial begin
    tracker         = new($sformatf("tps %0d", TPS), TPS);
    in_bus.valid    <= 1'b0;
    in_bus.opcode   <= pats_pkg::OP_TICK;
    in_bus.alarm_id <= pats_pkg::ALARM_ALL;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // malformed numbers and commands while silent
    send_word(pats_pkg::OP_REQUEST, pats_pkg::ALARM_ALL);
    send_word(pats_pkg::OP_REQUEST, ALARM_BAD_HI);
    send_word(pats_pkg::OP_REQUEST, ALARM_BAD_LO);
    send_word(pats_pkg::OP_SILENCE, ALARM_BAD_LO);
    send_word(pats_pkg::OP_SILENCE, ALARM_BAD_HI);
    send_word(OP_UNUSED, ALARM_BAD_HI);
    send_word(pats_pkg::OP_TICK, ALARM_BAD_HI);
    send_word(pats_pkg::OP_SILENCE, A_ASCENT);
    // lowest alarm through a full pattern wrap, then a repeated request
    send_word(pats_pkg::OP_REQUEST, A_DEPTH);
    tick_run(tracker.half_len + 1);
    tick_run(tracker.half_len);
    send_word(pats_pkg::OP_REQUEST, A_DEPTH);
    // preemption and restart on a lower request
    send_word(pats_pkg::OP_REQUEST, A_OUT_AIR);
    tick_run(tracker.quarter_len);
    send_word(pats_pkg::OP_REQUEST, A_ASCENT);
    tick_run(tracker.quarter_len + 1);
    send_word(pats_pkg::OP_SILENCE, A_ASCENT);
    send_word(pats_pkg::OP_TICK, pats_pkg::ALARM_ALL);
    send_word(pats_pkg::OP_SILENCE, A_OUT_AIR);
    send_word(pats_pkg::OP_SILENCE, A_DEPTH);
    send_word(pats_pkg::OP_REQUEST, A_ASCENT);
    send_word(pats_pkg::OP_REQUEST, A_DEPTH);
    send_word(pats_pkg::OP_SILENCE, pats_pkg::ALARM_ALL);
    send_word(pats_pkg::OP_TICK, 3'd5);
    hold_until_drained();

    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        hold_until_drained();
      end
      if ($urandom_range(0, 9) < 7) begin
        play_sequence();
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end
    end

    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches + tracker.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  always @(posedge clk_i) begin
    pats_pkg::result_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.tone_on       = out_bus.tone_on;
      got.tone_divider  = out_bus.tone_divider;
      got.playing_alarm = out_bus.playing_alarm;
      got.note_position = out_bus.note_position;
      got.active_mask   = out_bus.active_mask;
      got.bad_request   = out_bus.bad_request;
      tracker.check_tone(got);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
